@@ hdl/cau_pkg.sv @@
`default_nettype none

package cau_pkg;

  // Width of every operand and result field on the ports.
  localparam int unsigned FIELD_W = 32;
  // Exact width of a product of two fields.
  localparam int unsigned PROD_W = 2 * FIELD_W;
  // Signed width that holds a sum or difference of two products.
  localparam int unsigned SUM_W = PROD_W + 2;
  // Divider remainder: a shifted product magnitude, or the divisor moved up a full field.
  localparam int unsigned REM_W = PROD_W + FIELD_W + 1;
  // Square root steps, one result bit each.
  localparam int unsigned ROOT_STEPS = FIELD_W;

  // Bit positions of the result flags in the result tuser.
  localparam int unsigned USER_DZ  = 0;
  localparam int unsigned USER_SAT = 1;

  // Operation codes as they arrive on the input tuser.
  typedef enum logic [2:0] {
    MODE_ADD  = 3'd0,
    MODE_SUB  = 3'd1,
    MODE_MUL  = 3'd2,
    MODE_DIV  = 3'd3,
    MODE_CONJ = 3'd4,
    MODE_MAG  = 3'd5
  } mode_t;

  // Decoded operation, one-hot.
  typedef enum logic [6:0] {
    OP_ADD  = 7'b0000001,
    OP_SUB  = 7'b0000010,
    OP_MUL  = 7'b0000100,
    OP_DIV  = 7'b0001000,
    OP_CONJ = 7'b0010000,
    OP_MAG  = 7'b0100000,
    OP_NONE = 7'b1000000
  } op_t;

  // One classified transaction as it waits in the queue.
  typedef struct packed {
    op_t                       op;
    logic signed [FIELD_W-1:0] ar;
    logic signed [FIELD_W-1:0] ai;
    logic signed [FIELD_W-1:0] br;
    logic signed [FIELD_W-1:0] bi;
  } item_t;

  // Sign and magnitude form of an intermediate result.
  typedef struct packed {
    logic              neg;
    logic [PROD_W-1:0] mag;
  } sm_t;

  // A saturated result part and whether it was clipped.
  typedef struct packed {
    logic [FIELD_W-1:0] val;
    logic               flag;
  } sat_t;

  // Sign-extend a field from the working width.
  function automatic logic signed [FIELD_W-1:0] sext_work(input logic [FIELD_W-1:0] v,
                                                          input int unsigned w);
    logic [FIELD_W-1:0] t;
    t = v << (FIELD_W - w);
    return $signed(t) >>> (FIELD_W - w);
  endfunction

  // Split a signed sum into sign and magnitude.
  function automatic sm_t to_sm(input logic signed [SUM_W-1:0] v);
    sm_t                r;
    logic [SUM_W-1:0]   a;
    a     = v[SUM_W-1] ? (SUM_W'(0) - v) : v;
    r.neg = v[SUM_W-1];
    r.mag = a[PROD_W-1:0];
    return r;
  endfunction

  // Clip a sign and magnitude value to the signed working range.
  function automatic sat_t saturate(input sm_t v, input logic ovf, input int unsigned w);
    sat_t              r;
    logic [PROD_W-1:0] lim;
    logic [PROD_W-1:0] res;
    lim    = PROD_W'(1) << (w - 1);
    r.flag = 1'b0;
    if (v.neg) begin
      if (ovf || v.mag > lim) begin
        r.flag = 1'b1;
        res    = PROD_W'(0) - lim;
      end else begin
        res = PROD_W'(0) - v.mag;
      end
    end else begin
      if (ovf || v.mag > lim - PROD_W'(1)) begin
        r.flag = 1'b1;
        res    = lim - PROD_W'(1);
      end else begin
        res = v.mag;
      end
    end
    r.val = res[FIELD_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/cau_front.sv @@
`default_nettype none

module cau_front #(
  parameter int unsigned WORK_W = 32
) (
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic [127:0]   s_tdata,
  input  wire logic [2:0]     s_tuser,
  input  wire logic           full,
  output logic                push,
  output cau_pkg::item_t      item
);
  import cau_pkg::*;

  // A transaction is taken whenever the queue has room.
  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  // Decode the mode and bring the operands to the working width.
  always_comb begin
    case (s_tuser)
      MODE_ADD:  item.op = OP_ADD;
      MODE_SUB:  item.op = OP_SUB;
      MODE_MUL:  item.op = OP_MUL;
      MODE_DIV:  item.op = OP_DIV;
      MODE_CONJ: item.op = OP_CONJ;
      MODE_MAG:  item.op = OP_MAG;
      default:   item.op = OP_NONE;
    endcase
    item.ar = sext_work(s_tdata[31:0], WORK_W);
    item.ai = sext_work(s_tdata[63:32], WORK_W);
    item.br = sext_work(s_tdata[95:64], WORK_W);
    item.bi = sext_work(s_tdata[127:96], WORK_W);
  end

endmodule

`default_nettype wire

@@ hdl/cau_queue.sv @@
`default_nettype none

module cau_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire cau_pkg::item_t wr_item,
  output logic                full,
  input  wire logic           pop,
  output cau_pkg::item_t      rd_item,
  output logic                rd_valid
);
  import cau_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t          slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> rd_valid)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

@@ hdl/cau_back.sv @@
`default_nettype none

module cau_back #(
  parameter int unsigned WORK_W    = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire cau_pkg::item_t q_item,
  output logic                pop,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [63:0]         m_tdata,   // res_re, res_im
  output logic [1:0]          m_tuser    // divide_by_zero, saturated
);
  import cau_pkg::*;

  // Divider overflow check plus one quotient bit per stage; the root runs alongside.
  localparam int unsigned NSTG = FIELD_W + 1;
  localparam logic [FIELD_W-1:0] RES_MAX =
    FIELD_W'((PROD_W'(1) << (WORK_W - 1)) - PROD_W'(1));
  localparam logic [FIELD_W-1:0] RES_MIN = ~RES_MAX;

  typedef struct packed {
    logic               valid;
    op_t                op;
    logic               dz;
    sm_t                re_sm;
    sm_t                im_sm;
    logic [REM_W-1:0]   rem_re;
    logic [REM_W-1:0]   rem_im;
    logic               ovf_re;
    logic               ovf_im;
    logic [FIELD_W-1:0] q_re;
    logic [FIELD_W-1:0] q_im;
    logic [PROD_W-1:0]  sqsum;
    logic [PROD_W-1:0]  root_n;
    logic [PROD_W-1:0]  root_r;
  } stage_t;

  logic                      en;
  logic                      s1_valid;
  op_t                       s1_op;
  logic signed [FIELD_W-1:0] s1_ar, s1_ai, s1_br, s1_bi;
  logic signed [PROD_W-1:0]  p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;
  stage_t                    pipe [NSTG+1];
  stage_t                    head;
  sat_t                      fin_re, fin_im;

  // The whole pipeline moves whenever the output register can take a result.
  assign en  = !m_tvalid || m_tready;
  assign pop = en && q_valid;

  // Stage one: the six products.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op <= q_item.op;
      s1_ar <= q_item.ar;
      s1_ai <= q_item.ai;
      s1_br <= q_item.br;
      s1_bi <= q_item.bi;
      p_rr  <= q_item.ar * q_item.br;
      p_ii  <= q_item.ai * q_item.bi;
      p_ri  <= q_item.ar * q_item.bi;
      p_ir  <= q_item.ai * q_item.br;
      sq_r  <= (q_item.op == OP_MAG) ? q_item.ar * q_item.ar : q_item.br * q_item.br;
      sq_i  <= (q_item.op == OP_MAG) ? q_item.ai * q_item.ai : q_item.bi * q_item.bi;
    end
  end

  // Stage two: combine the products into the results or into divider and root inputs.
  always_comb begin
    logic signed [SUM_W-1:0] sre;
    logic signed [SUM_W-1:0] sim;
    sm_t                     rsm;
    sm_t                     ism;
    case (s1_op)
      OP_ADD: begin
        sre = SUM_W'(s1_ar) + SUM_W'(s1_br);
        sim = SUM_W'(s1_ai) + SUM_W'(s1_bi);
      end
      OP_SUB: begin
        sre = SUM_W'(s1_ar) - SUM_W'(s1_br);
        sim = SUM_W'(s1_ai) - SUM_W'(s1_bi);
      end
      OP_MUL: begin
        sre = SUM_W'(p_rr) - SUM_W'(p_ii);
        sim = SUM_W'(p_ri) + SUM_W'(p_ir);
      end
      OP_DIV: begin
        sre = SUM_W'(p_rr) + SUM_W'(p_ii);
        sim = SUM_W'(p_ir) - SUM_W'(p_ri);
      end
      OP_CONJ: begin
        sre = SUM_W'(s1_ar);
        sim = SUM_W'(0) - SUM_W'(s1_ai);
      end
      default: begin
        sre = '0;
        sim = '0;
      end
    endcase
    rsm = to_sm(sre);
    ism = to_sm(sim);
    head.valid  = s1_valid;
    head.op     = s1_op;
    head.sqsum  = $unsigned(sq_r) + $unsigned(sq_i);
    head.dz     = (s1_op == OP_DIV) && (head.sqsum == '0);
    head.rem_re = REM_W'(rsm.mag) << FRAC_BITS;
    head.rem_im = REM_W'(ism.mag) << FRAC_BITS;
    head.ovf_re = 1'b0;
    head.ovf_im = 1'b0;
    head.q_re   = '0;
    head.q_im   = '0;
    head.root_n = head.sqsum;
    head.root_r = '0;
    // Products carry twice the fraction bits; drop the extra ones toward zero.
    if (s1_op == OP_MUL) begin
      rsm.mag = rsm.mag >> FRAC_BITS;
      ism.mag = ism.mag >> FRAC_BITS;
    end
    head.re_sm = rsm;
    head.im_sm = ism;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].valid <= 1'b0;
    end else if (en) begin
      pipe[0] <= head;
    end
  end

  // Divider and square root stages, one result bit each.
  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    stage_t nxt;

    always_comb begin
      logic [REM_W-1:0]  dsh;
      logic [PROD_W:0]   trial;
      logic [PROD_W-1:0] rbit;
      nxt   = pipe[s];
      dsh   = '0;
      trial = '0;
      rbit  = '0;
      // Quotient: first rule out a quotient past the working range, then restore bits.
      if (s == 0) begin
        dsh        = REM_W'(pipe[s].sqsum) << WORK_W;
        nxt.ovf_re = (pipe[s].rem_re >= dsh);
        nxt.ovf_im = (pipe[s].rem_im >= dsh);
      end else if (s <= WORK_W) begin
        dsh = REM_W'(pipe[s].sqsum) << (WORK_W - s);
        if (pipe[s].rem_re >= dsh) begin
          nxt.rem_re              = pipe[s].rem_re - dsh;
          nxt.q_re[WORK_W - s]    = 1'b1;
        end
        if (pipe[s].rem_im >= dsh) begin
          nxt.rem_im              = pipe[s].rem_im - dsh;
          nxt.q_im[WORK_W - s]    = 1'b1;
        end
      end
      // Root: one digit pair per stage.
      if (s < ROOT_STEPS) begin
        rbit  = PROD_W'(1) << (2 * (ROOT_STEPS - 1 - s));
        trial = (PROD_W + 1)'(pipe[s].root_r) + (PROD_W + 1)'(rbit);
        if ((PROD_W + 1)'(pipe[s].root_n) >= trial) begin
          nxt.root_n = pipe[s].root_n - trial[PROD_W-1:0];
          nxt.root_r = (pipe[s].root_r >> 1) + rbit;
        end else begin
          nxt.root_r = pipe[s].root_r >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[s+1].valid <= 1'b0;
      end else if (en) begin
        pipe[s+1] <= nxt;
      end
    end
  end

  // Pick the finished result for the operation and clip it.
  always_comb begin
    sm_t qre;
    sm_t qim;
    sm_t rt;
    qre.neg = pipe[NSTG].re_sm.neg;
    qre.mag = PROD_W'(pipe[NSTG].q_re);
    qim.neg = pipe[NSTG].im_sm.neg;
    qim.mag = PROD_W'(pipe[NSTG].q_im);
    rt.neg  = 1'b0;
    rt.mag  = pipe[NSTG].root_r;
    case (pipe[NSTG].op)
      OP_DIV: begin
        if (pipe[NSTG].dz) begin
          fin_re = '0;
          fin_im = '0;
        end else begin
          fin_re = saturate(qre, pipe[NSTG].ovf_re, WORK_W);
          fin_im = saturate(qim, pipe[NSTG].ovf_im, WORK_W);
        end
      end
      OP_MAG: begin
        fin_re = saturate(rt, 1'b0, WORK_W);
        fin_im = '0;
      end
      default: begin
        fin_re = saturate(pipe[NSTG].re_sm, 1'b0, WORK_W);
        fin_im = saturate(pipe[NSTG].im_sm, 1'b0, WORK_W);
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= pipe[NSTG].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata           <= {fin_im.val, fin_re.val};
      m_tuser[USER_DZ]  <= pipe[NSTG].dz;
      m_tuser[USER_SAT] <= fin_re.flag || fin_im.flag;
    end
  end

`ifndef SYNTHESIS
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tuser[USER_DZ]) |-> (m_tdata == '0 && !m_tuser[USER_SAT]))
    else $error("divide by zero result is not a clean zero");
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tuser[USER_SAT]) |->
      (m_tdata[31:0] == RES_MAX || m_tdata[31:0] == RES_MIN ||
       m_tdata[63:32] == RES_MAX || m_tdata[63:32] == RES_MIN))
    else $error("saturation flag without a result at a range limit");
`endif

endmodule

`default_nettype wire

@@ hdl/complex_arithmetic_unit.sv @@
// Path: queue, product and combine registers, divider and root stages, output.
// Throughput: one transaction per cycle unless stalled; the divider and square
// root are fully pipelined, one quotient or root bit per stage, so any mix of
// modes streams. A four-entry queue sits between decoder and pipeline.
// Reset (rst, synchronous, active high) empties the queue and the pipeline.
`default_nettype none

module complex_arithmetic_unit #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,   // a_re, a_im, b_re, b_im
  input  wire logic [2:0]   s_tuser,   // mode
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [63:0]       m_tdata,   // res_re, res_im
  output logic [1:0]        m_tuser    // divide_by_zero, saturated
);
  import cau_pkg::*;

  localparam int unsigned WORK_W = (DATA_WIDTH > FIELD_W) ? FIELD_W : DATA_WIDTH;
  localparam int unsigned QDEPTH = 4;

  logic  full;
  logic  push;
  item_t wr_item;
  logic  pop;
  item_t rd_item;
  logic  rd_valid;

  cau_front #(.WORK_W(WORK_W)) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .full     (full),
    .push     (push),
    .item     (wr_item)
  );

  cau_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_item  (wr_item),
    .full     (full),
    .pop      (pop),
    .rd_item  (rd_item),
    .rd_valid (rd_valid)
  );

  cau_back #(.WORK_W(WORK_W), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (rd_valid),
    .q_item   (rd_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import cau_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned N_RANDOM = 1400;
  localparam longint CYCLE_LIMIT = 400000;

  // One expected result.
  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        dz;
    logic        sat;
  } cplx_res_t;

  // Sign and magnitude intermediate, wide enough for any sum of two products.
  typedef struct {
    bit       neg;
    bit [66:0] mag;
  } smag_t;

  // Scoreboard: computes each expected result and checks results in order.
  class cau_scoreboard;
    cplx_res_t pending[$];
    int        errors;
    int        checked;

    function smag_t from_signed(longint signed p);
      smag_t r;
      r.neg = p < 0;
      r.mag = r.neg ? 67'(-p) : 67'(p);
      return r;
    endfunction

    function smag_t from_signed_wide(logic signed [66:0] p);
      smag_t r;
      r.neg = p[66];
      r.mag = r.neg ? -p : p;
      return r;
    endfunction

    function smag_t add_sm(smag_t x, smag_t y);
      smag_t r;
      if (x.neg == y.neg) begin
        r.neg = x.neg;
        r.mag = x.mag + y.mag;
      end else if (x.mag >= y.mag) begin
        r.neg = x.neg;
        r.mag = x.mag - y.mag;
      end else begin
        r.neg = y.neg;
        r.mag = y.mag - x.mag;
      end
      if (r.mag == 0) r.neg = 0;
      return r;
    endfunction

    function smag_t neg_sm(smag_t x);
      if (x.mag != 0) x.neg = !x.neg;
      return x;
    endfunction

    // Clip to the signed 32-bit range and report whether clipping happened.
    function logic [31:0] clip(smag_t v, inout logic flag);
      if (v.neg) begin
        if (v.mag > 67'h80000000) begin
          flag = 1;
          return 32'h80000000;
        end
        return 32'(-v.mag);
      end
      if (v.mag > 67'h7fffffff) begin
        flag = 1;
        return 32'h7fffffff;
      end
      return 32'(v.mag);
    endfunction

    // Truncating fixed-point quotient; a huge integer part skips the fraction.
    function smag_t fix_div(smag_t num, bit [66:0] den);
      smag_t r;
      bit [98:0] q;
      r.neg = num.neg;
      q = num.mag / den;
      if (q > 99'h80000000) begin
        r.mag = 67'(q);
        return r;
      end
      q = ({32'd0, num.mag} << FRAC) / den;
      r.mag = 67'(q);
      if (r.mag == 0) r.neg = 0;
      return r;
    endfunction

    function bit [66:0] int_sqrt(bit [66:0] n);
      bit [66:0] r, b;
      r = 0;
      b = 67'd1 << 64;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        bit_step: b >>= 2;
      end
      return r;
    endfunction

    function void note_operands(logic [2:0] mode, logic [31:0] ar_u, logic [31:0] ai_u,
                                logic [31:0] br_u, logic [31:0] bi_u);
      cplx_res_t e;
      longint signed ar, ai, br, bi;
      smag_t re, im;
      smag_t t0, t1;
      bit [66:0] den;
      ar = longint'($signed(ar_u));
      ai = longint'($signed(ai_u));
      br = longint'($signed(br_u));
      bi = longint'($signed(bi_u));
      e = '{32'd0, 32'd0, 1'b0, 1'b0};
      case (mode)
        MODE_ADD: begin
          e.re = clip(from_signed(ar + br), e.sat);
          e.im = clip(from_signed(ai + bi), e.sat);
        end
        MODE_SUB: begin
          e.re = clip(from_signed(ar - br), e.sat);
          e.im = clip(from_signed(ai - bi), e.sat);
        end
        MODE_MUL: begin
          re = add_sm(from_signed_wide(67'(ar) * 67'(br)),
                      neg_sm(from_signed_wide(67'(ai) * 67'(bi))));
          im = add_sm(from_signed_wide(67'(ar) * 67'(bi)),
                      from_signed_wide(67'(ai) * 67'(br)));
          re.mag >>= FRAC;
          im.mag >>= FRAC;
          if (re.mag == 0) re.neg = 0;
          if (im.mag == 0) im.neg = 0;
          e.re = clip(re, e.sat);
          e.im = clip(im, e.sat);
        end
        MODE_DIV: begin
          t0 = from_signed_wide(67'(br) * 67'(br));
          t1 = from_signed_wide(67'(bi) * 67'(bi));
          den = t0.mag + t1.mag;
          if (den == 0) begin
            e.dz = 1;
          end else begin
            re = add_sm(from_signed_wide(67'(ar) * 67'(br)),
                        from_signed_wide(67'(ai) * 67'(bi)));
            im = add_sm(from_signed_wide(67'(ai) * 67'(br)),
                        neg_sm(from_signed_wide(67'(ar) * 67'(bi))));
            e.re = clip(fix_div(re, den), e.sat);
            e.im = clip(fix_div(im, den), e.sat);
          end
        end
        MODE_CONJ: begin
          e.re = ar_u;
          e.im = clip(from_signed(-ai), e.sat);
        end
        MODE_MAG: begin
          t0 = from_signed_wide(67'(ar) * 67'(ar));
          t1 = from_signed_wide(67'(ai) * 67'(ai));
          re.neg = 0;
          re.mag = int_sqrt(t0.mag + t1.mag);
          e.re = clip(re, e.sat);
        end
        default: ;
      endcase
      pending.push_back(e);
    endfunction

    task check_result(logic [31:0] re, logic [31:0] im, logic dz, logic sat);
      cplx_res_t e;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch("result arrived with none expected");
        return;
      end
      e = pending.pop_front();
      if (re !== e.re)
        report_mismatch($sformatf("res_re %h, expected %h", re, e.re));
      if (im !== e.im)
        report_mismatch($sformatf("res_im %h, expected %h", im, e.im));
      if (dz !== e.dz)
        report_mismatch($sformatf("divide_by_zero %b, expected %b", dz, e.dz));
      if (sat !== e.sat)
        report_mismatch($sformatf("saturated %b, expected %b", sat, e.sat));
    endtask

    task report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH at result %0d: %s", checked, msg);
    endtask
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;   // a_re, a_im, b_re, b_im
  logic [2:0]   s_tuser;   // mode
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;   // res_re, res_im
  logic [1:0]   m_tuser;   // divide_by_zero, saturated

  cau_scoreboard sb;
  longint        cycles;
  int            sent;
  bit            stim_done;

  complex_arithmetic_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Check every result transaction and count cycles at the rising edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[31:0], m_tdata[63:32], m_tuser[USER_DZ], m_tuser[USER_SAT]);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  // Receiver: open windows; else random spells, mostly ready or mostly stalled.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if ((cycles / 64) % 4 == 3) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) < ((cycles / 200) % 2 ? 30 : 80));
    end
  end

  // Present one transaction and hold it until accepted; valid stays high on return.
  task automatic send_operands(logic [2:0] mode, logic [31:0] ar, logic [31:0] ai,
                               logic [31:0] br, logic [31:0] bi);
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {bi, br, ai, ar};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_operands(mode, ar, ai, br, bi);
    sent++;
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    s_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Operand values that favor edges, small numbers and plain random words.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'(signed'($urandom_range(0, 8)) - 4);
      3: return 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
      4: return 32'($urandom_range(0, 32'h1ffffff)) - 32'h1000000;
      default: return $urandom();
    endcase
  endfunction

  logic [31:0] edge_vals[6] = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff,
                                32'h00010000, 32'hffff0000};

  initial begin
    int burst;
    logic [2:0] m;
    logic [31:0] br, bi;
    sb = new();
    cycles = 0;
    sent = 0;
    stim_done = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: each mode on extremes, divide by zero, unused modes.
    for (int md = 0; md < 6; md++)
      send_operands(3'(md), edge_vals[md], edge_vals[(md + 1) % 6],
                    edge_vals[(md + 2) % 6], edge_vals[(md + 4) % 6]);
    send_operands(MODE_ADD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_operands(MODE_SUB, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_operands(MODE_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_operands(MODE_MUL, 32'h00018000, 32'hfffe8000, 32'h00020000, 32'h00008000);
    send_operands(MODE_DIV, 32'h00050000, 32'hfffd0000, 32'h0, 32'h0);
    send_operands(MODE_DIV, 32'h7fffffff, 32'h7fffffff, 32'h00000001, 32'h0);
    send_operands(MODE_DIV, 32'h00010000, 32'hffff0000, 32'h00030000, 32'hfffc0000);
    send_operands(MODE_DIV, 32'hffffffff, 32'h0, 32'h7fffffff, 32'h80000000);
    send_operands(MODE_CONJ, 32'h12345678, 32'h80000000, 32'h0, 32'h0);
    send_operands(MODE_MAG, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
    send_operands(MODE_MAG, 32'h00030000, 32'hfffc0000, 32'h0, 32'h0);
    send_operands(3'd6, 32'h1, 32'h2, 32'h3, 32'h4);
    send_operands(3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);

    // Let everything drain before the random part.
    idle_cycles(1);
    while (sb.pending.size() != 0) @(negedge clk);

    // Random bursts with random gaps, plus full stop-and-drain pauses.
    while (sent < N_RANDOM + 19) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      repeat (burst) begin
        m = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        br = pick_value();
        bi = pick_value();
        if (m == MODE_DIV && $urandom_range(0, 9) == 0) begin
          br = 0;
          bi = 0;
        end
        send_operands(m, pick_value(), pick_value(), br, bi);
      end
      if ($urandom_range(0, 19) == 0) begin
        idle_cycles(1);
        while (sb.pending.size() != 0) @(negedge clk);
      end else if ($urandom_range(0, 1) == 0) begin
        idle_cycles($urandom_range(1, 20));
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then watch a little longer for stray results.
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);

    $display("Sent %0d operand pairs across all six modes, unused modes and divide by zero,",
             sent);
    $display("with bursty input and a stalling receiver; %0d results checked.", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/cau_pkg.sv
hdl/cau_front.sv
hdl/cau_queue.sv
hdl/cau_back.sv
hdl/complex_arithmetic_unit.sv
bench/tb.sv
